// ----- rtl/ftpf_pkg.sv -----
// Shared types, constants and codes of the five-tuple packet filter.
package ftpf_pkg;

  localparam int RuleDepth = 64;
  localparam int IdxW      = $clog2(RuleDepth);
  localparam int CntW      = $clog2(RuleDepth + 1);
  localparam int RuleW     = 1 + 8 + 32 + 32 + 16 + 32 + 32 + 16;
  localparam int QDepth    = 2;

  localparam logic [7:0] IpprotoIcmp = 8'd1;
  localparam logic [7:0] IpprotoTcp  = 8'd6;
  localparam logic [7:0] IpprotoUdp  = 8'd17;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_RESULT
  } scan_state_e;

  typedef struct packed {
    logic        inbound;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [15:0] dst_port;
  } rule_t;

  // One classified command moving from the front end to the scan engine.
  typedef struct packed {
    op_e   op;
    logic  examine;
    rule_t rule;
  } cmd_t;

  function automatic logic rule_hits(rule_t r, rule_t p);
    logic hit;
    hit = (r.protocol == 8'd0 || r.protocol == p.protocol) &&
          (r.src_addr == 32'd0 || ((r.src_addr ^ p.src_addr) & r.src_mask) == 32'd0) &&
          (r.src_port == 16'd0 || r.src_port == p.src_port) &&
          (r.dst_addr == 32'd0 || ((r.dst_addr ^ p.dst_addr) & r.dst_mask) == 32'd0) &&
          (r.dst_port == 16'd0 || r.dst_port == p.dst_port);
    return hit;
  endfunction

endpackage

// ----- rtl/ftpf_ram.sv -----
// Generic single-port RAM with registered read.
module ftpf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- rtl/ftpf_front.sv -----
// Front end: accepts beats, normalizes fields and queues commands.
module ftpf_front import ftpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  operation_i,
  input  logic        direction_i,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] src_mask_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] dst_addr_i,
  input  logic [31:0] dst_mask_i,
  input  logic [15:0] dst_port_i,
  output logic        cmd_valid_o,
  input  logic        cmd_take_i,
  output cmd_t        cmd_o
);
  cmd_t             q_q [QDepth];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  cmd_t             c;
  logic             acc, take;

  always_comb begin
    logic icmp;
    icmp = protocol_i == IpprotoIcmp;
    c = '0;
    c.op = op_e'(operation_i);
    c.examine = protocol_i == IpprotoTcp || protocol_i == IpprotoUdp || icmp;
    c.rule.inbound  = direction_i;
    c.rule.protocol = protocol_i;
    c.rule.src_addr = src_addr_i;
    c.rule.src_mask = src_mask_i;
    c.rule.dst_addr = dst_addr_i;
    c.rule.dst_mask = dst_mask_i;
    // ICMP packet checks are compared as ports 0.
    c.rule.src_port = (icmp && c.op == OP_CHECK) ? 16'd0 : src_port_i;
    c.rule.dst_port = (icmp && c.op == OP_CHECK) ? 16'd0 : dst_port_i;
  end

  assign full_o      = cnt_q == 2'(QDepth);
  assign acc         = push_i && !full_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign take        = cmd_take_i && cmd_valid_o;
  assign cmd_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (acc) q_q[wr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (acc) wr_q <= !wr_q;
      if (take) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(acc) - 2'(take);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("command queue overflow");
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !take |=> full_o) else $error("full dropped without a take");
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> cnt_q != 2'd0) else $error("take from empty queue");
`endif
endmodule

// ----- rtl/ftpf_engine.sv -----
// Back end: scans the rule table for checks and removes, and puts adds in the lowest free entry.
module ftpf_engine import ftpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_take_o,
  input  cmd_t       cmd_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic       verdict_o,
  output logic [1:0] status_o
);
  scan_state_e      state_q, state_d;
  logic [RuleDepth-1:0] valid_q, valid_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  rd_idx_q;
  // Index of the first entry that hit during the scan.
  logic [IdxW-1:0]  hit_idx_q;
  logic             rd_live_q;
  logic             found_q, found_d;
  cmd_t             cmd_q;
  logic             verdict_q, verdict_d;
  status_e          status_q, status_d;
  logic             we;
  logic [IdxW-1:0]  addr;
  rule_t            rdata, wdata;
  logic [RuleDepth-1:0] free_vec;
  logic             any_free;
  logic [IdxW-1:0]  free_idx;
  logic             hit;

  assign addr  = we ? free_idx : idx_q;
  assign wdata = cmd_q.rule;

  ftpf_ram #(.Width(RuleW), .Depth(RuleDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // Lowest free entry: priority encoder over the valid flops.
  always_comb begin
    free_vec = ~valid_q;
    any_free = |free_vec;
    free_idx = '0;
    for (int i = RuleDepth - 1; i >= 0; i--) begin
      if (free_vec[i]) free_idx = IdxW'(i);
    end
  end

  always_comb begin
    hit = 1'b0;
    if (rd_live_q && valid_q[rd_idx_q] && rdata.inbound == cmd_q.rule.inbound) begin
      if (cmd_q.op == OP_CHECK) hit = rule_hits(rdata, cmd_q.rule);
      else hit = rdata == cmd_q.rule;
    end
  end

  assign cmd_take_o = state_q == S_IDLE;
  assign empty_o    = state_q != S_RESULT;
  assign verdict_o  = verdict_q;
  assign status_o   = status_q;

  always_comb begin
    state_d = state_q; valid_d = valid_q; idx_d = idx_q; found_d = found_q;
    verdict_d = verdict_q; status_d = status_q; we = 1'b0;
    case (state_q)
      S_IDLE: begin
        idx_d = '0; found_d = 1'b0;
        if (cmd_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cmd_q.op == OP_ADD) begin
          we = any_free;
          if (any_free) valid_d[free_idx] = 1'b1;
          verdict_d = 1'b0;
          status_d  = any_free ? ST_DONE : ST_FULL;
          state_d   = S_RESULT;
        end else if (cmd_q.op == OP_NOP || (cmd_q.op == OP_CHECK && !cmd_q.examine)) begin
          verdict_d = 1'b0; status_d = ST_DONE; state_d = S_RESULT;
        end else begin
          if (hit) begin
            found_d = 1'b1; state_d = S_WAIT;
          end else if (idx_q == IdxW'(RuleDepth - 1)) begin
            state_d = S_WAIT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_WAIT: begin
        // Last read lands here; the previous cycle's hit was already seen.
        if (!found_q && hit) found_d = 1'b1;
        if (cmd_q.op == OP_CHECK) begin
          verdict_d = found_d; status_d = ST_DONE;
        end else begin
          verdict_d = 1'b0;
          status_d = found_d ? ST_DONE : ST_NOMATCH;
          if (found_d) valid_d[found_q ? hit_idx_q : rd_idx_q] = 1'b0;
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (pop_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    rd_idx_q <= idx_q;
    if (hit && !found_q) hit_idx_q <= rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; valid_q <= '0; idx_q <= '0; found_q <= 1'b0;
      verdict_q <= 1'b0; status_q <= ST_DONE; rd_live_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; found_q <= found_d;
      verdict_q <= verdict_d; status_q <= status_d;
      rd_live_q <= state_q == S_SCAN && state_d == S_SCAN ||
                   state_q == S_SCAN && state_d == S_WAIT && !found_d;
      valid_q <= valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> empty_o) else $error("take while result pending");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(status_o))
    else $error("result changed while waiting");
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && cmd_q.op == OP_ADD && valid_q == '1 |=> status_q == ST_FULL)
    else $error("full table not reported");
`endif
endmodule

// ----- rtl/five_tuple_packet_filter.sv -----
// Top level of the five-tuple packet filter.
// Adds and filtered-out checks pass from S_IDLE through S_SCAN to S_RESULT; a scan reads
// one rule per cycle from the rule RAM, then passes through S_WAIT to S_RESULT.
// The scan engine holds one beat at a time and takes the next only after its result is
// popped; a two-entry command queue decouples push.
// Reset clears the valid flags of all rules at once; no clearing pass is needed.
module five_tuple_packet_filter import ftpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic        direction_i,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] src_mask_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] dst_addr_i,
  input  logic [31:0] dst_mask_i,
  input  logic [15:0] dst_port_i,
  output logic        empty,
  input  logic        pop,
  output logic        verdict_o,
  output logic [1:0]  status_o
);
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  ftpf_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .operation_i, .direction_i, .protocol_i, .src_addr_i, .src_mask_i,
    .src_port_i, .dst_addr_i, .dst_mask_i, .dst_port_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  ftpf_engine u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .empty_o(empty), .pop_i(pop), .verdict_o, .status_o
  );
endmodule

// ----- tb/ftpf_checker.sv -----
// Checker for the five-tuple packet filter: rule table predictor and result scoreboard.
module ftpf_checker import ftpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  operation_i,
  input  logic        direction_i,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] src_mask_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] dst_addr_i,
  input  logic [31:0] dst_mask_i,
  input  logic [15:0] dst_port_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        verdict_o,
  input  logic [1:0]  status_o,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic    verdict;
    status_e status;
  } outcome_t;

  logic  rule_valid [RuleDepth];
  rule_t rule_mem   [RuleDepth];
  outcome_t expected_q [$];

  function automatic logic matches_rule(rule_t r, rule_t pkt);
    logic ok;
    ok = (r.protocol == 8'd0 || r.protocol == pkt.protocol);
    ok = ok && (r.src_addr == 32'd0 || ((r.src_addr ^ pkt.src_addr) & r.src_mask) == 32'd0);
    ok = ok && (r.src_port == 16'd0 || r.src_port == pkt.src_port);
    ok = ok && (r.dst_addr == 32'd0 || ((r.dst_addr ^ pkt.dst_addr) & r.dst_mask) == 32'd0);
    ok = ok && (r.dst_port == 16'd0 || r.dst_port == pkt.dst_port);
    return ok;
  endfunction

  // Applies one command to the predicted table and returns its outcome.
  function automatic outcome_t filter_command(op_e op, rule_t cmd);
    outcome_t res;
    res.verdict = 1'b0;
    res.status  = ST_DONE;
    case (op)
      OP_CHECK: begin
        if (cmd.protocol inside {IpprotoTcp, IpprotoUdp, IpprotoIcmp}) begin
          if (cmd.protocol == IpprotoIcmp) begin
            cmd.src_port = '0;
            cmd.dst_port = '0;
          end
          for (int i = 0; i < RuleDepth; i++) begin
            if (rule_valid[i] && rule_mem[i].inbound == cmd.inbound &&
                matches_rule(rule_mem[i], cmd)) begin
              res.verdict = 1'b1;
              break;
            end
          end
        end
      end
      OP_ADD: begin
        res.status = ST_FULL;
        for (int i = 0; i < RuleDepth; i++) begin
          if (!rule_valid[i]) begin
            rule_valid[i] = 1'b1;
            rule_mem[i]   = cmd;
            res.status    = ST_DONE;
            break;
          end
        end
      end
      OP_REMOVE: begin
        res.status = ST_NOMATCH;
        for (int i = 0; i < RuleDepth; i++) begin
          if (rule_valid[i] && rule_mem[i] == cmd) begin
            rule_valid[i] = 1'b0;
            res.status    = ST_DONE;
            break;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rule_t    cmd;
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < RuleDepth; i++) rule_valid[i] = 1'b0;
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (!empty && pop) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat verdict=%0d status=%0d", $time, verdict_o, status_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (verdict_o !== want.verdict || status_o !== want.status) begin
            $display("%0t: mismatch expected verdict=%0d status=%0d, actual verdict=%0d status=%0d",
                     $time, want.verdict, want.status, verdict_o, status_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (push && !full) begin
        cmd = '{inbound: direction_i, protocol: protocol_i, src_addr: src_addr_i,
                src_mask: src_mask_i, src_port: src_port_i, dst_addr: dst_addr_i,
                dst_mask: dst_mask_i, dst_port: dst_port_i};
        expected_q.push_back(filter_command(op_e'(operation_i), cmd));
      end
    end
  end

endmodule

// ----- tb/tb_five_tuple_packet_filter.sv -----
// Testbench top for the five-tuple packet filter: stimulus, stalls and the verdict.
module tb_five_tuple_packet_filter;
  import ftpf_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation_i = '0;
  logic        direction_i = 1'b0;
  logic [7:0]  protocol_i = '0;
  logic [31:0] src_addr_i = '0;
  logic [31:0] src_mask_i = '0;
  logic [15:0] src_port_i = '0;
  logic [31:0] dst_addr_i = '0;
  logic [31:0] dst_mask_i = '0;
  logic [15:0] dst_port_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        verdict_o;
  logic [1:0]  status_o;
  int          fail_count;
  int          pending;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;
  int  quiet_cycles = 0;

  // Rules sent in random adds (at most 80 kept), so that checks and removes can hit them.
  rule_t rule_pool [$];

  always #5 clk_i = ~clk_i;

  five_tuple_packet_filter dut (.*);

  ftpf_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("tb_five_tuple_packet_filter: FAIL");
      $finish;
    end
  end

  task automatic send_beat(op_e op, rule_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    operation_i <= op;
    direction_i <= r.inbound;
    protocol_i  <= r.protocol;
    src_addr_i  <= r.src_addr;
    src_mask_i  <= r.src_mask;
    src_port_i  <= r.src_port;
    dst_addr_i  <= r.dst_addr;
    dst_mask_i  <= r.dst_mask;
    dst_port_i  <= r.dst_port;
    do @(posedge clk_i); while (full);
  endtask

  function automatic rule_t random_rule();
    rule_t r;
    r = RuleW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(5))
      0: r.protocol = 8'd0;
      1: r.protocol = IpprotoIcmp;
      2: r.protocol = IpprotoTcp;
      3: r.protocol = IpprotoUdp;
      default: ;
    endcase
    if ($urandom_range(3) == 0) r.src_addr = '0;
    if ($urandom_range(3) == 0) r.dst_addr = '0;
    if ($urandom_range(2) == 0) r.src_port = '0;
    if ($urandom_range(2) == 0) r.dst_port = '0;
    if ($urandom_range(1)) r.src_mask = ~32'd0 << $urandom_range(32);
    if ($urandom_range(1)) r.dst_mask = ~32'd0 << $urandom_range(32);
    return r;
  endfunction

  // A packet derived from a stored rule, so that it usually matches.
  function automatic rule_t packet_near(rule_t r);
    rule_t p;
    p = random_rule();
    if (r.protocol != 8'd0) p.protocol = r.protocol;
    p.inbound  = $urandom_range(7) ? r.inbound : ~r.inbound;
    p.src_addr = (r.src_addr & r.src_mask) | (p.src_addr & ~r.src_mask);
    p.dst_addr = (r.dst_addr & r.dst_mask) | (p.dst_addr & ~r.dst_mask);
    if (r.src_port != 16'd0) p.src_port = r.src_port;
    if (r.dst_port != 16'd0) p.dst_port = r.dst_port;
    if ($urandom_range(9) == 0) p.dst_port = p.dst_port + 16'd1;
    return p;
  endfunction

  task automatic random_beat();
    rule_t r;
    int    k;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 25 || rule_pool.size() == 0) begin
      r = random_rule();
      send_beat(OP_ADD, r);
      if (rule_pool.size() < 80) rule_pool.push_back(r);
    end else if (pick < 40) begin
      k = $urandom_range(rule_pool.size() - 1);
      r = rule_pool[k];
      if ($urandom_range(5) == 0) r.src_mask = r.src_mask ^ 32'h1;
      else rule_pool.delete(k);
      send_beat(OP_REMOVE, r);
    end else if (pick < 90) begin
      send_beat(OP_CHECK, packet_near(rule_pool[$urandom_range(rule_pool.size() - 1)]));
    end else if (pick < 97) begin
      send_beat(OP_CHECK, random_rule());
    end else begin
      send_beat(OP_NOP, random_rule());
    end
  endtask

  initial begin
    rule_t r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation, field extremes, other protocols, ICMP port rule,
    // remove with no match, the NOP operation.
    r = '0;
    send_beat(OP_CHECK, r);
    r = '1;
    send_beat(OP_CHECK, r);
    send_beat(OP_REMOVE, r);
    send_beat(OP_ADD, r);
    r.protocol = IpprotoTcp;
    send_beat(OP_CHECK, r);
    r = '1;
    send_beat(OP_REMOVE, r);
    r = '0;
    r.inbound = 1'b1;
    r.protocol = IpprotoIcmp;
    r.src_port = 16'd80;
    send_beat(OP_ADD, r);
    r.src_port = 16'd5;
    send_beat(OP_CHECK, r);
    r.protocol = IpprotoTcp;
    r.src_port = 16'd80;
    send_beat(OP_CHECK, r);
    r = '0;
    send_beat(OP_ADD, r);
    r.protocol = 8'd50;
    send_beat(OP_CHECK, r);
    r.protocol = IpprotoUdp;
    send_beat(OP_CHECK, r);
    r.inbound = 1'b1;
    send_beat(OP_CHECK, r);
    r = '1;
    send_beat(OP_NOP, r);
    // Fill the table past full with duplicates, remove one, add two back, then remove them all.
    r = '0;
    r.protocol = 8'd99;
    repeat (64) send_beat(OP_ADD, r);
    send_beat(OP_REMOVE, r);
    send_beat(OP_ADD, r);
    send_beat(OP_ADD, r);
    repeat (64) send_beat(OP_REMOVE, r);
    push <= 1'b0;
    wait (pending == 0);
    rst_ni <= 1'b1;

    // Long receiver hold-off while the sender keeps pushing.
    hold_off <= 1'b1;
    fork
      repeat (200) @(posedge clk_i);
      repeat (30) random_beat();
    join_any
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b0;
    wait fork;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (220) random_beat();
    end
    push <= 1'b0;
    recv_stall_pct = 0;
    wait (pending == 0);
    repeat (RuleDepth + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("tb_five_tuple_packet_filter: PASS");
    else $display("tb_five_tuple_packet_filter: FAIL");
    $finish;
  end

endmodule

// ----- five_tuple_packet_filter.f -----
rtl/ftpf_pkg.sv
rtl/ftpf_ram.sv
rtl/ftpf_front.sv
rtl/ftpf_engine.sv
rtl/five_tuple_packet_filter.sv
tb/ftpf_checker.sv
tb/tb_five_tuple_packet_filter.sv
